/* sv/crc32_packet_deframer_defines.svh */
// assertion macros for the packet deframer
// expects clk and rst in the scope of use
`ifndef CRC32_PACKET_DEFRAMER_DEFINES_SVH
`define CRC32_PACKET_DEFRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CRCDFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crcdfr implication check failed");
`define CRCDFR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("crcdfr invariant check failed");
`else
`define CRCDFR_ASSERT_IMP(lbl, ante, cons)
`define CRCDFR_ASSERT_ALWAYS(lbl, cond)
`endif

`endif

/* sv/crcdfr_pkg.sv */
// types, codes and helpers for the packet deframer
// no dependencies
`default_nettype none
package crcdfr_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  data_byte;
    logic [10:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [0:0]  result_kind;
    logic [2:0]  verdict;
    logic [7:0]  packet_type;
    logic [31:0] sequence_number;
    logic [31:0] payload_size;
    logic [5:0]  status_text_length;
    logic [1:0]  frame_orientation;
    logic [0:0]  ready_flag;
    logic [7:0]  read_data;
  } out_item_t;

  localparam logic [1:0] OP_RECV       = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_LINK_RESET = 2'd2;

  localparam logic [0:0] KIND_VERDICT = 1'b0;
  localparam logic [0:0] KIND_READ    = 1'b1;

  localparam logic [2:0] V_BAD_CRC   = 3'd0;
  localparam logic [2:0] V_TOO_LARGE = 3'd1;
  localparam logic [2:0] V_READY     = 3'd2;
  localparam logic [2:0] V_STATUS    = 3'd3;
  localparam logic [2:0] V_FRAME     = 3'd4;
  localparam logic [2:0] V_IGNORED   = 3'd5;

  localparam logic [7:0] TYPE_READY  = 8'd2;
  localparam logic [7:0] TYPE_FRAME  = 8'd3;
  localparam logic [7:0] TYPE_STATUS = 8'd6;

  localparam logic [1:0] REG_MAGIC     = 2'd0;
  localparam logic [1:0] REG_VERSION   = 2'd1;
  localparam logic [1:0] REG_MAX_PAY   = 2'd2;
  localparam logic [1:0] REG_FRAME_LEN = 2'd3;

  localparam logic [31:0] MAGIC_RESET     = 32'd826495558;
  localparam logic [7:0]  VERSION_RESET   = 8'd1;
  localparam logic [11:0] MAX_PAY_RESET   = 12'd1100;
  localparam logic [11:0] FRAME_LEN_RESET = 12'd1025;

  localparam int unsigned HDR_LEN       = 20;
  localparam logic [4:0]  HDR_LEN_C     = 5'd20;
  localparam logic [5:0]  STATUS_TEXT_MAX = 6'd63;
  localparam logic [7:0]  ORIENT_LIMIT  = 8'd4;
  localparam logic [31:0] CRC_POLY      = 32'hedb88320;
  localparam logic [31:0] CRC_INIT      = 32'hffffffff;

  // reflected crc32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* sv/crcdfr_ram.sv */
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module crcdfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* sv/crc32_packet_deframer.sv */
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready  | crcdfr_pkg::in_item_t
// out     | out | out_valid / out_ready| crcdfr_pkg::out_item_t
// cfg     | in  | cfg_write            | cfg_index, cfg_data
// a payload byte is taken in the idle state; a header byte also passes through
// the scan state, staying there while bytes are dropped hunting for the magic
// a read waits in ST_READ for the store port, a packet end in ST_FIN for its verdict
// reset is synchronous; no clearing pass, the store is undefined until written
// a result waiting on out_ready stalls only items that would need the output
// depends on crcdfr_pkg, crcdfr_ram and crc32_packet_deframer_defines.svh
`default_nettype none
module crc32_packet_deframer #(
  parameter int PAYLOAD_DEPTH = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire crcdfr_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output crcdfr_pkg::out_item_t      out_data,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [31:0]           cfg_data
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state;
  logic [31:0] magic_word;
  logic [7:0]  protocol_version;
  logic [11:0] max_payload;
  logic [11:0] frame_payload_length;

  logic [7:0]  hdr [crcdfr_pkg::HDR_LEN];
  logic [4:0]  hdr_count;
  logic        in_payload;
  logic [11:0] pay_count;
  logic [11:0] exp_len;
  logic [7:0]  held_type;
  logic [31:0] held_seq;
  logic [31:0] held_size;
  logic [31:0] exp_crc;
  logic [31:0] run_crc;
  logic        bridge_ready;
  logic [7:0]  first_byte;
  logic        too_large;
  logic        rd_oor;

  logic        accept;
  logic        slot_free;
  logic        magic_ok;
  logic [31:0] hdr_len32;
  logic [31:0] final_crc;
  logic        ram_we;
  logic        ram_re;
  logic [7:0]  ram_q;
  logic        load;
  logic        set_ready;
  crcdfr_pkg::out_item_t out_data_next;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign magic_ok  = ({hdr[3], hdr[2], hdr[1], hdr[0]} == magic_word);
  assign hdr_len32 = {hdr[15], hdr[14], hdr[13], hdr[12]};
  assign final_crc = (exp_len != 12'd0) ? ~run_crc : 32'd0;
  assign ram_we    = accept && (in_data.operation == crcdfr_pkg::OP_RECV) && in_payload &&
                     (32'(pay_count) < 32'(PAYLOAD_DEPTH));
  assign ram_re    = accept && (in_data.operation == crcdfr_pkg::OP_READ);

  crcdfr_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(pay_count)),
    .wr_data (in_data.data_byte),
    .rd_en   (ram_re),
    .rd_addr (AW'(in_data.read_index)),
    .rd_data (ram_q)
  );

  // result built from the read or the end of a packet
  always_comb begin
    out_data_next = '0;
    load          = 1'b0;
    set_ready     = 1'b0;
    if (state == ST_READ) begin
      load                        = slot_free;
      out_data_next.result_kind   = crcdfr_pkg::KIND_READ;
      out_data_next.ready_flag    = bridge_ready;
      out_data_next.read_data     = rd_oor ? 8'd0 : ram_q;
    end else if (state == ST_FIN) begin
      load                            = slot_free;
      out_data_next.result_kind       = crcdfr_pkg::KIND_VERDICT;
      out_data_next.packet_type       = held_type;
      out_data_next.sequence_number   = held_seq;
      out_data_next.ready_flag        = bridge_ready;
      if (too_large) begin
        out_data_next.verdict      = crcdfr_pkg::V_TOO_LARGE;
        out_data_next.payload_size = held_size;
      end else begin
        out_data_next.payload_size = 32'(exp_len);
        if (final_crc != exp_crc) begin
          out_data_next.verdict = crcdfr_pkg::V_BAD_CRC;
        end else if (held_type == crcdfr_pkg::TYPE_READY && exp_len == 12'd0) begin
          out_data_next.verdict    = crcdfr_pkg::V_READY;
          out_data_next.ready_flag = 1'b1;
          set_ready                = 1'b1;
        end else if (held_type == crcdfr_pkg::TYPE_STATUS) begin
          out_data_next.verdict            = crcdfr_pkg::V_STATUS;
          out_data_next.status_text_length =
            (exp_len > 12'(crcdfr_pkg::STATUS_TEXT_MAX)) ?
            crcdfr_pkg::STATUS_TEXT_MAX : exp_len[5:0];
        end else if (held_type == crcdfr_pkg::TYPE_FRAME && exp_len != 12'd0 &&
                     exp_len == frame_payload_length &&
                     first_byte < crcdfr_pkg::ORIENT_LIMIT) begin
          out_data_next.verdict           = crcdfr_pkg::V_FRAME;
          out_data_next.frame_orientation = first_byte[1:0];
        end else begin
          out_data_next.verdict = crcdfr_pkg::V_IGNORED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_IDLE;
      magic_word           <= crcdfr_pkg::MAGIC_RESET;
      protocol_version     <= crcdfr_pkg::VERSION_RESET;
      max_payload          <= crcdfr_pkg::MAX_PAY_RESET;
      frame_payload_length <= crcdfr_pkg::FRAME_LEN_RESET;
      hdr_count            <= 5'd0;
      in_payload           <= 1'b0;
      pay_count            <= 12'd0;
      exp_len              <= 12'd0;
      held_type            <= 8'd0;
      held_seq             <= 32'd0;
      held_size            <= 32'd0;
      exp_crc              <= 32'd0;
      run_crc              <= crcdfr_pkg::CRC_INIT;
      bridge_ready         <= 1'b0;
      too_large            <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        out_data  <= out_data_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          crcdfr_pkg::REG_MAGIC:     magic_word           <= cfg_data;
          crcdfr_pkg::REG_VERSION:   protocol_version     <= cfg_data[7:0];
          crcdfr_pkg::REG_MAX_PAY:   max_payload          <= cfg_data[11:0];
          crcdfr_pkg::REG_FRAME_LEN: frame_payload_length <= cfg_data[11:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_data.operation)
              crcdfr_pkg::OP_RECV: begin
                if (!in_payload) begin
                  hdr[hdr_count] <= in_data.data_byte;
                  hdr_count      <= hdr_count + 5'd1;
                  state          <= ST_SCAN;
                end else begin
                  if (pay_count == 12'd0) begin
                    first_byte <= in_data.data_byte;
                  end
                  run_crc   <= crcdfr_pkg::crc_byte(run_crc, in_data.data_byte);
                  pay_count <= pay_count + 12'd1;
                  if ({1'b0, pay_count} + 13'd1 >= {1'b0, exp_len}) begin
                    too_large <= 1'b0;
                    state     <= ST_FIN;
                  end
                end
              end
              crcdfr_pkg::OP_READ: begin
                rd_oor <= (32'(in_data.read_index) >= 32'(PAYLOAD_DEPTH));
                state  <= ST_READ;
              end
              crcdfr_pkg::OP_LINK_RESET: begin
                hdr_count    <= 5'd0;
                in_payload   <= 1'b0;
                pay_count    <= 12'd0;
                exp_len      <= 12'd0;
                held_type    <= 8'd0;
                held_seq     <= 32'd0;
                exp_crc      <= 32'd0;
                run_crc      <= crcdfr_pkg::CRC_INIT;
                bridge_ready <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (hdr_count >= 5'd4 && !magic_ok) begin
            // slide the window by one byte and look again
            for (int i = 0; i < crcdfr_pkg::HDR_LEN - 1; i++) begin
              hdr[i] <= hdr[i+1];
            end
            hdr[crcdfr_pkg::HDR_LEN-1] <= 8'd0;
            hdr_count <= hdr_count - 5'd1;
          end else if (hdr_count == crcdfr_pkg::HDR_LEN_C) begin
            if (hdr[4] != protocol_version) begin
              // drop one byte only; the rescan waits for the next byte
              for (int i = 0; i < crcdfr_pkg::HDR_LEN - 1; i++) begin
                hdr[i] <= hdr[i+1];
              end
              hdr[crcdfr_pkg::HDR_LEN-1] <= 8'd0;
              hdr_count <= hdr_count - 5'd1;
              state     <= ST_IDLE;
            end else begin
              held_type <= hdr[5];
              held_seq  <= {hdr[11], hdr[10], hdr[9], hdr[8]};
              held_size <= hdr_len32;
              exp_crc   <= {hdr[19], hdr[18], hdr[17], hdr[16]};
              if (hdr_len32 > 32'(max_payload)) begin
                too_large <= 1'b1;
                state     <= ST_FIN;
              end else begin
                exp_len   <= hdr_len32[11:0];
                pay_count <= 12'd0;
                run_crc   <= crcdfr_pkg::CRC_INIT;
                hdr_count <= 5'd0;
                too_large <= 1'b0;
                if (hdr_len32 == 32'd0) begin
                  state <= ST_FIN;
                end else begin
                  in_payload <= 1'b1;
                  state      <= ST_IDLE;
                end
              end
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            if (set_ready) begin
              bridge_ready <= 1'b1;
            end
            hdr_count  <= 5'd0;
            in_payload <= 1'b0;
            pay_count  <= 12'd0;
            exp_len    <= 12'd0;
            held_type  <= 8'd0;
            held_seq   <= 32'd0;
            exp_crc    <= 32'd0;
            run_crc    <= crcdfr_pkg::CRC_INIT;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "crc32_packet_deframer_defines.svh"

  `CRCDFR_ASSERT_ALWAYS(a_hdr_bound, hdr_count <= crcdfr_pkg::HDR_LEN_C)
  `CRCDFR_ASSERT_IMP(a_payload_no_hdr, in_payload, hdr_count == 5'd0)
  `CRCDFR_ASSERT_IMP(a_ready_flag, out_valid && out_data.result_kind == crcdfr_pkg::KIND_VERDICT && out_data.verdict == crcdfr_pkg::V_READY, out_data.ready_flag == 1'b1)

endmodule
`default_nettype wire

/* bench/crc32_packet_deframer_tb.sv */
// self-checking bench for the crc32 packet deframer: framed packets, noise, reads
// and link resets go in, every verdict and read result is checked against a predictor
// depends on crcdfr_pkg and the crc32_packet_deframer rtl
`default_nettype none
module crc32_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 2048;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  class deframer_scoreboard;
    crcdfr_pkg::out_item_t pending[$];
    int          errors;
    logic [31:0] magic;
    logic [7:0]  version;
    logic [11:0] max_len;
    logic [11:0] frame_len;
    logic [7:0]  hdr[crcdfr_pkg::HDR_LEN];
    int unsigned hdr_count;
    bit          in_body;
    int unsigned body_count;
    int unsigned body_len;
    logic [7:0]  pkt_type;
    logic [31:0] pkt_seq;
    logic [31:0] pkt_crc;
    logic [31:0] run_crc;
    logic [7:0]  store[STORE_DEPTH];
    int unsigned written;
    bit          link_ready;

    function new();
      errors = 0;
      magic = crcdfr_pkg::MAGIC_RESET;
      version = crcdfr_pkg::VERSION_RESET;
      max_len = crcdfr_pkg::MAX_PAY_RESET;
      frame_len = crcdfr_pkg::FRAME_LEN_RESET;
      written = 0;
      link_ready = 0;
      clear();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) x = x[0] ? ((x >> 1) ^ crcdfr_pkg::CRC_POLY) : (x >> 1);
      return x;
    endfunction

    function void clear();
      foreach (hdr[i]) hdr[i] = 8'd0;
      hdr_count = 0;
      in_body = 0;
      body_count = 0;
      body_len = 0;
      pkt_type = 8'd0;
      pkt_seq = 32'd0;
      pkt_crc = 32'd0;
      run_crc = crcdfr_pkg::CRC_INIT;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        crcdfr_pkg::REG_MAGIC:     magic = v;
        crcdfr_pkg::REG_VERSION:   version = v[7:0];
        crcdfr_pkg::REG_MAX_PAY:   max_len = v[11:0];
        crcdfr_pkg::REG_FRAME_LEN: frame_len = v[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] le32(int p);
      return {hdr[p+3], hdr[p+2], hdr[p+1], hdr[p]};
    endfunction

    function void slide();
      for (int i = 0; i < crcdfr_pkg::HDR_LEN - 1; i++) hdr[i] = hdr[i+1];
      hdr[crcdfr_pkg::HDR_LEN-1] = 8'd0;
      if (hdr_count > 0) hdr_count--;
    endfunction

    function crcdfr_pkg::out_item_t verdict_item(logic [2:0] v, logic [31:0] len);
      crcdfr_pkg::out_item_t r;
      r = '0;
      r.result_kind = crcdfr_pkg::KIND_VERDICT;
      r.verdict = v;
      r.packet_type = pkt_type;
      r.sequence_number = pkt_seq;
      r.payload_size = len;
      return r;
    endfunction

    function void close_packet();
      crcdfr_pkg::out_item_t r;
      logic [31:0] crc;
      crc = (body_len != 0) ? ~run_crc : 32'd0;
      if (crc != pkt_crc) r = verdict_item(crcdfr_pkg::V_BAD_CRC, body_len);
      else if (pkt_type == crcdfr_pkg::TYPE_READY && body_len == 0) begin
        link_ready = 1;
        r = verdict_item(crcdfr_pkg::V_READY, body_len);
      end else if (pkt_type == crcdfr_pkg::TYPE_STATUS) begin
        r = verdict_item(crcdfr_pkg::V_STATUS, body_len);
        r.status_text_length = (body_len > crcdfr_pkg::STATUS_TEXT_MAX) ?
                               crcdfr_pkg::STATUS_TEXT_MAX : body_len[5:0];
      end else if (pkt_type == crcdfr_pkg::TYPE_FRAME && body_len != 0 &&
                   body_len == frame_len && store[0] < crcdfr_pkg::ORIENT_LIMIT) begin
        r = verdict_item(crcdfr_pkg::V_FRAME, body_len);
        r.frame_orientation = store[0][1:0];
      end else r = verdict_item(crcdfr_pkg::V_IGNORED, body_len);
      r.ready_flag = link_ready;
      pending.push_back(r);
      clear();
    endfunction

    function void take_byte(logic [7:0] b);
      crcdfr_pkg::out_item_t r;
      logic [31:0] len;
      if (!in_body) begin
        if (hdr_count >= crcdfr_pkg::HDR_LEN) hdr_count = crcdfr_pkg::HDR_LEN - 1;
        hdr[hdr_count] = b;
        hdr_count++;
        while (hdr_count >= 4 && le32(0) != magic) slide();
        if (hdr_count != crcdfr_pkg::HDR_LEN) return;
        // wrong version: drop one byte and keep hunting
        if (hdr[4] != version) begin
          slide();
          return;
        end
        pkt_type = hdr[5];
        pkt_seq = le32(8);
        len = le32(12);
        pkt_crc = le32(16);
        if (len > {20'd0, max_len}) begin
          r = verdict_item(crcdfr_pkg::V_TOO_LARGE, len);
          r.ready_flag = link_ready;
          pending.push_back(r);
          clear();
          return;
        end
        body_len = len;
        body_count = 0;
        run_crc = crcdfr_pkg::CRC_INIT;
        hdr_count = 0;
        if (len == 0) begin
          close_packet();
          return;
        end
        in_body = 1;
        return;
      end
      if (body_count < STORE_DEPTH) begin
        store[body_count] = b;
        if (body_count + 1 > written) written = body_count + 1;
      end
      run_crc = crc_step(run_crc, b);
      body_count++;
      if (body_count >= body_len) close_packet();
    endfunction

    function void note(crcdfr_pkg::in_item_t it);
      crcdfr_pkg::out_item_t r;
      case (it.operation)
        crcdfr_pkg::OP_RECV: take_byte(it.data_byte);
        crcdfr_pkg::OP_READ: begin
          r = '0;
          r.result_kind = crcdfr_pkg::KIND_READ;
          r.ready_flag = link_ready;
          r.read_data = store[it.read_index];
          pending.push_back(r);
        end
        crcdfr_pkg::OP_LINK_RESET: begin
          clear();
          link_ready = 0;
        end
        default: ;
      endcase
    endfunction

    function void check(crcdfr_pkg::out_item_t a);
      crcdfr_pkg::out_item_t e;
      bit        bad;
      if (pending.size() == 0) begin
        if (errors < 10) $display("unexpected result %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      bad = (a.result_kind !== e.result_kind) || (a.verdict !== e.verdict) ||
            (a.packet_type !== e.packet_type) || (a.sequence_number !== e.sequence_number) ||
            (a.payload_size !== e.payload_size) ||
            (a.status_text_length !== e.status_text_length) ||
            (a.frame_orientation !== e.frame_orientation) ||
            (a.ready_flag !== e.ready_flag) || (a.read_data !== e.read_data);
      if (bad) begin
        if (errors < 10) $display("mismatch: expected %h actual %h", e, a);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  crcdfr_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  crcdfr_pkg::out_item_t out_data;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = crcdfr_pkg::REG_MAGIC;
  logic [31:0] cfg_data = 32'd0;

  deframer_scoreboard sb = new();
  bit calm = 0;
  int sent = 0;
  int stall_left = 0;

  crc32_packet_deframer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check(out_data);
  end

  task automatic send(crcdfr_pkg::in_item_t it);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(it);
    sent++;
  endtask

  task automatic rx(logic [7:0] b);
    crcdfr_pkg::in_item_t it;
    it.operation = crcdfr_pkg::OP_RECV;
    it.data_byte = b;
    it.read_index = 11'($urandom);
    send(it);
  endtask

  task automatic rx32(logic [31:0] v);
    for (int i = 0; i < 4; i++) rx(v[8*i +: 8]);
  endtask

  task automatic other_op(logic [1:0] op);
    crcdfr_pkg::in_item_t it;
    it.operation = op;
    it.data_byte = 8'($urandom);
    it.read_index = 11'($urandom);
    if (op == crcdfr_pkg::OP_READ) begin
      if (sb.written == 0) return;
      it.read_index = 11'($urandom_range(0, sb.written - 1));
    end
    send(it);
  endtask

  task automatic read_at(int idx);
    crcdfr_pkg::in_item_t it;
    it.operation = crcdfr_pkg::OP_READ;
    it.data_byte = 8'($urandom);
    it.read_index = idx[10:0];
    send(it);
  endtask

  // first < 0 leaves the first payload byte random
  task automatic send_packet(logic [7:0] ver, logic [7:0] kind, logic [31:0] len,
                             bit corrupt, int first);
    logic [7:0]  body[$];
    logic [31:0] crc;
    logic [7:0]  b;
    crc = crcdfr_pkg::CRC_INIT;
    if (len <= {20'd0, sb.max_len} && ver == sb.version) begin
      for (int i = 0; i < int'(len); i++) begin
        b = (i == 0 && first >= 0) ? first[7:0] : 8'($urandom);
        body.push_back(b);
        crc = deframer_scoreboard::crc_step(crc, b);
      end
    end
    crc = (len != 0) ? ~crc : 32'd0;
    if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    rx32(sb.magic);
    rx(ver);
    rx(kind);
    rx(8'($urandom));
    rx(8'($urandom));
    rx32($urandom);
    rx32(len);
    rx32(crc);
    foreach (body[i]) rx(body[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] m, logic [7:0] v, logic [11:0] mp, logic [11:0] fl);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= crcdfr_pkg::REG_MAGIC;
    cfg_data <= m;
    sb.set_reg(crcdfr_pkg::REG_MAGIC, m);
    @(posedge clk);
    cfg_index <= crcdfr_pkg::REG_VERSION;
    cfg_data <= {24'd0, v};
    sb.set_reg(crcdfr_pkg::REG_VERSION, {24'd0, v});
    @(posedge clk);
    cfg_index <= crcdfr_pkg::REG_MAX_PAY;
    cfg_data <= {20'd0, mp};
    sb.set_reg(crcdfr_pkg::REG_MAX_PAY, {20'd0, mp});
    @(posedge clk);
    cfg_index <= crcdfr_pkg::REG_FRAME_LEN;
    cfg_data <= {20'd0, fl};
    sb.set_reg(crcdfr_pkg::REG_FRAME_LEN, {20'd0, fl});
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_traffic(int count, int quiet_from);
    int          stop;
    int unsigned r;
    logic [7:0]  kind;
    logic [31:0] len;
    int          first;
    stop = sent + count;
    while (sent < stop) begin
      if (sent >= quiet_from) calm = 1;
      r = $urandom_range(0, 99);
      if (r < 62) begin
        case ($urandom_range(0, 3))
          0: kind = crcdfr_pkg::TYPE_READY;
          1: kind = crcdfr_pkg::TYPE_FRAME;
          2: kind = crcdfr_pkg::TYPE_STATUS;
          default: kind = 8'($urandom);
        endcase
        len = (sb.max_len == 0 || $urandom_range(0, 3) == 0) ? 32'd0 :
              $urandom_range(1, (sb.max_len < 24) ? sb.max_len : 24);
        first = -1;
        if (kind == crcdfr_pkg::TYPE_FRAME && sb.frame_len <= sb.max_len &&
            $urandom_range(0, 1)) begin
          len = {20'd0, sb.frame_len};
          first = $urandom_range(0, 7);
        end
        send_packet(sb.version, kind, len, r >= 54, first);
      end else if (r < 67) send_packet(sb.version ^ 8'($urandom_range(1, 255)),
                                       crcdfr_pkg::TYPE_STATUS, 32'd0, 0, -1);
      else if (r < 72) send_packet(sb.version, 8'($urandom),
                                   $urandom_range(0, 1) ? 32'hffffffff :
                                   {20'd0, sb.max_len} + $urandom_range(1, 2000), 0, -1);
      else if (r < 86) other_op(crcdfr_pkg::OP_READ);
      else if (r < 89) other_op(crcdfr_pkg::OP_LINK_RESET);
      else if (r < 97) rx(8'($urandom));
      else other_op(OP_UNUSED);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed checks at reset configuration
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_READY, 32'd0, 0, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_READY, 32'd3, 0, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_STATUS, 32'd70, 0, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_STATUS, 32'd0, 0, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_STATUS, 32'd5, 1, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, 8'hff, 32'hffffffff, 0, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, 8'h00, 32'd1101, 0, -1);
    send_packet(8'hfe, crcdfr_pkg::TYPE_READY, 32'd0, 0, -1);
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_FRAME, 32'd5, 0, 2);
    send_packet(crcdfr_pkg::VERSION_RESET, 8'hff, 32'd2, 0, -1);
    read_at(0);
    read_at(sb.written - 1);
    other_op(crcdfr_pkg::OP_LINK_RESET);
    read_at(1);
    other_op(OP_UNUSED);
    rx(8'h00);
    rx(8'hff);
    other_op(crcdfr_pkg::OP_LINK_RESET);

    // top extremes: all-ones magic and version, a payload limit at the store depth, a frame and an oversize status
    configure(32'hffffffff, 8'hff, 12'd2048, 12'd40);
    send_packet(8'hff, crcdfr_pkg::TYPE_FRAME, 32'd40, 0, 3);
    read_at(39);
    read_at(20);
    send_packet(8'hff, crcdfr_pkg::TYPE_STATUS, 32'd2049, 0, -1);

    // bottom extremes: only empty packets fit, a zero-length frame is ignored
    configure(32'h00000000, 8'h00, 12'd0, 12'd0);
    send_packet(8'h00, crcdfr_pkg::TYPE_FRAME, 32'd0, 0, -1);
    random_traffic(150, 1 << 30);

    configure(crcdfr_pkg::MAGIC_RESET, crcdfr_pkg::VERSION_RESET, 12'd64, 12'd5);
    send_packet(crcdfr_pkg::VERSION_RESET, crcdfr_pkg::TYPE_FRAME, 32'd5, 0, 200);
    random_traffic(700, 1 << 30);

    configure($urandom, 8'h80, 12'd40, 12'd1);
    random_traffic(550, sent + 400);

    calm = 1;
    drain();
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/crcdfr_pkg.sv
sv/crcdfr_ram.sv
sv/crc32_packet_deframer.sv
bench/crc32_packet_deframer_tb.sv
